>>> src/ibt_pkg.sv
// ibt_pkg: shared types, sizes and codes for the IPC binding table.
// No dependencies; used by every module of the block.
package ibt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int PROC_ID_BITS  = 8;
	localparam int PERM_W        = 32;
	localparam int CNT_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [PROC_ID_BITS-1:0] ID_EMPTY = {PROC_ID_BITS{1'b1}};

	localparam logic [2:0] REQ_CREATE  = 3'd0;
	localparam logic [2:0] REQ_GET     = 3'd1;
	localparam logic [2:0] REQ_UPDATE  = 3'd2;
	localparam logic [2:0] REQ_DESTROY = 3'd3;
	localparam logic [2:0] REQ_CLEANUP = 3'd4;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [PROC_ID_BITS-1:0] sender;
		logic [PROC_ID_BITS-1:0] receiver;
		logic [PERM_W-1:0]       perms;
	} entry_t;

	localparam entry_t ENTRY_CLEAR = '{sender: ID_EMPTY, receiver: ID_EMPTY, perms: '0};

endpackage

>>> src/ibt_cell.sv
// ibt_cell: one table entry of the rotating ring.
// Depends on ibt_pkg (entry_t, reset value).
module ibt_cell
	import ibt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  entry_t d,
	output entry_t q
);

	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= ENTRY_CLEAR;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

>>> src/ibt_ctrl.sv
// ibt_ctrl: request sequencer; inspects the head cell each step and
// feeds the edited entry back to the tail. Holds the result register.
// Depends on ibt_pkg.
module ibt_ctrl
	import ibt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [2:0]              req_type,
	input  logic [7:0]              sender_id,
	input  logic [7:0]              receiver_id,
	input  logic [PERM_W-1:0]       perm_in,
	input  logic [7:0]              requester_id,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [1:0]              status,
	output logic [PERM_W-1:0]       perm_out,
	output logic                    notify_valid,
	output logic [7:0]              notify_target,
	output logic [7:0]              notify_about,
	output logic                    last,
	input  entry_t                  head,
	output entry_t                  tail,
	output logic                    shift
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [2:0]              op_q;
	logic [PROC_ID_BITS-1:0] snd_q, rcv_q, req_q, tgt_q;
	logic [PERM_W-1:0]       perm_q, rd_q;
	logic                    found_q;

	logic                    out_valid_q;
	logic [1:0]              status_q;
	logic [PERM_W-1:0]       perm_out_q;
	logic                    nv_q, last_q;
	logic [PROC_ID_BITS-1:0] ntgt_q, nabout_q;

	logic                    out_free, match, is_empty, step, emit, hit;
	logic [PROC_ID_BITS-1:0] tgt_sel;
	entry_t                  nxt;

	assign out_free = !out_valid_q || !rsp_stall;
	assign match    = (head.sender == snd_q) && (head.receiver == rcv_q);
	assign is_empty = (head.sender == ID_EMPTY) && (head.receiver == ID_EMPTY);
	assign tgt_sel  = (head.receiver == req_q) ? head.sender : head.receiver;

	always_comb begin
		nxt  = head;
		step = 1'b1;
		emit = 1'b0;
		hit  = 1'b0;
		case (op_q)
			REQ_CREATE: begin
				if (!found_q && is_empty) begin
					nxt = '{sender: snd_q, receiver: rcv_q, perms: perm_q};
					hit = 1'b1;
				end
			end
			REQ_GET: begin
				hit = !found_q && match;
			end
			REQ_UPDATE: begin
				if (!found_q && match) begin
					nxt.perms = perm_q;
					hit = 1'b1;
				end
			end
			REQ_DESTROY: begin
				if (!found_q && match) begin
					nxt = ENTRY_CLEAR;
					hit = 1'b1;
				end
			end
			REQ_CLEANUP: begin
				if (head.sender == req_q) begin
					emit = 1'b1;
					step = out_free;
					nxt  = ENTRY_CLEAR;
				end else if (head.receiver == req_q) begin
					nxt = ENTRY_CLEAR;
				end
			end
			default: begin
			end
		endcase
	end

	assign shift     = (state_q == S_SCAN) && step;
	assign tail      = nxt;
	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (step) begin
						if (hit) begin
							found_q <= 1'b1;
						end
						if (cnt_q == CNT_W'(TABLE_ENTRIES - 1)) begin
							state_q <= S_DONE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (((state_q == S_SCAN) && emit && out_free) ||
			    ((state_q == S_DONE) && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request operands and captured lookup data
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) begin
			op_q   <= req_type;
			snd_q  <= sender_id[PROC_ID_BITS-1:0];
			rcv_q  <= receiver_id[PROC_ID_BITS-1:0];
			perm_q <= perm_in;
			req_q  <= requester_id[PROC_ID_BITS-1:0];
		end
		if ((state_q == S_SCAN) && hit) begin
			rd_q  <= head.perms;
			tgt_q <= tgt_sel;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if ((state_q == S_SCAN) && emit && out_free) begin
			status_q   <= STAT_OK;
			perm_out_q <= '0;
			nv_q       <= 1'b1;
			ntgt_q     <= tgt_sel;
			nabout_q   <= req_q;
			last_q     <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			case (op_q)
				REQ_CREATE:                      status_q <= found_q ? STAT_OK : STAT_FULL;
				REQ_GET, REQ_UPDATE, REQ_DESTROY: status_q <= found_q ? STAT_OK : STAT_NOT_FOUND;
				REQ_CLEANUP:                     status_q <= STAT_OK;
				default:                         status_q <= STAT_NOT_FOUND;
			endcase
			perm_out_q <= ((op_q == REQ_GET) && found_q) ? rd_q : '0;
			nv_q       <= (op_q == REQ_DESTROY) && found_q;
			ntgt_q     <= ((op_q == REQ_DESTROY) && found_q) ? tgt_q : '0;
			nabout_q   <= ((op_q == REQ_DESTROY) && found_q) ? req_q : '0;
			last_q     <= 1'b1;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign status        = status_q;
	assign perm_out      = perm_out_q;
	assign notify_valid  = nv_q;
	assign notify_target = ntgt_q;
	assign notify_about  = nabout_q;
	assign last          = last_q;

endmodule

>>> src/ipc_binding_table.sv
// ipc_binding_table: top level of the IPC binding table.
// Depends on ibt_pkg, ibt_cell and ibt_ctrl.
//
// The table is a ring of TABLE_ENTRIES cells that rotates by one entry per
// cycle while a request is served, unless the result port stalls a cleanup
// word; the sequencer edits the entry at the head and passes it to the tail,
// so after a full turn the table is back in order. Each request is accepted,
// served by a single turn of the ring, and ends with its last word. Cleanup
// words are issued during the scan; a stalled result port pauses the ring
// only while a cleanup word waits. Requests are stalled while one is in
// progress. After reset all entries are free.
module ipc_binding_table
	import ibt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [2:0]        req_type,
	input  logic [7:0]        sender_id,
	input  logic [7:0]        receiver_id,
	input  logic [PERM_W-1:0] perm_in,
	input  logic [7:0]        requester_id,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [1:0]        status,
	output logic [PERM_W-1:0] perm_out,
	output logic              notify_valid,
	output logic [7:0]        notify_target,
	output logic [7:0]        notify_about,
	output logic              last
);

	entry_t cell_q [TABLE_ENTRIES];
	entry_t tail;
	logic   shift;

	genvar g;
	generate
		for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
			entry_t d;
			if (g == TABLE_ENTRIES - 1) begin : g_tail
				assign d = tail;
			end else begin : g_mid
				assign d = cell_q[g+1];
			end
			ibt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (d),
				.q      (cell_q[g])
			);
		end
	endgenerate

	ibt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.sender_id     (sender_id),
		.receiver_id   (receiver_id),
		.perm_in       (perm_in),
		.requester_id  (requester_id),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.perm_out      (perm_out),
		.notify_valid  (notify_valid),
		.notify_target (notify_target),
		.notify_about  (notify_about),
		.last          (last),
		.head          (cell_q[0]),
		.tail          (tail),
		.shift         (shift)
	);

endmodule

>>> tb/ipc_binding_table_test.sv
`timescale 1ns / 100ps
// ipc_binding_table_test: self-checking testbench for the IPC binding table.
// Needs ibt_pkg and ipc_binding_table; keeps its own copy of the table to
// predict result words not typed in by a fixed row, after a directed table and random phases.
module ipc_binding_table_test;
	import ibt_pkg::*;

	localparam logic [2:0] REQ_BAD_LO = 3'd5;
	localparam logic [2:0] REQ_BAD_HI = 3'd7;
	localparam int         HOLD_CYCLES = 300;

	typedef struct packed {
		logic [2:0]        op;
		logic [7:0]        sender;
		logic [7:0]        receiver;
		logic [PERM_W-1:0] perm;
		logic [7:0]        requester;
	} req_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PERM_W-1:0] perm;
		logic              notify;
		logic [7:0]        target;
		logic [7:0]        about;
		logic              last;
	} rsp_word_t;

	typedef struct packed {
		req_item_t it;
		logic      fixed;
		rsp_word_t want;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [2:0]        req_type = REQ_GET;
	logic [7:0]        sender_id = '0;
	logic [7:0]        receiver_id = '0;
	logic [PERM_W-1:0] perm_in = '0;
	logic [7:0]        requester_id = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic [1:0]        status;
	logic [PERM_W-1:0] perm_out;
	logic              notify_valid;
	logic [7:0]        notify_target;
	logic [7:0]        notify_about;
	logic              last;

	// typed-in expectation travelling with the offered word
	logic      cur_fixed = 1'b0;
	rsp_word_t cur_fixed_word = '0;

	logic [7:0]        bind_sender   [TABLE_ENTRIES];
	logic [7:0]        bind_receiver [TABLE_ENTRIES];
	logic [PERM_W-1:0] bind_perms    [TABLE_ENTRIES];
	rsp_word_t         due_replies[$];
	dir_row_t          directed_rows[$];

	int errors = 0;
	bit quiet = 1'b0;
	int bursts_asked = 0;
	int bursts_done = 0;
	int hold_left = 0;

	ipc_binding_table u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.sender_id    (sender_id),
		.receiver_id  (receiver_id),
		.perm_in      (perm_in),
		.requester_id (requester_id),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.perm_out     (perm_out),
		.notify_valid (notify_valid),
		.notify_target(notify_target),
		.notify_about (notify_about),
		.last         (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int find_binding(logic [7:0] s, logic [7:0] r);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (bind_sender[i] == s && bind_receiver[i] == r) return i;
		end
		return -1;
	endfunction

	function automatic logic [7:0] notify_peer(int slot, logic [7:0] req);
		return (bind_receiver[slot] == req) ? bind_sender[slot] : bind_receiver[slot];
	endfunction

	function automatic void clear_binding(int slot);
		bind_sender[slot]   = ID_EMPTY;
		bind_receiver[slot] = ID_EMPTY;
		bind_perms[slot]    = '0;
	endfunction

	// updates the table copy and queues the reply words of one request
	function automatic void apply_request(req_item_t it);
		int        slot;
		rsp_word_t w;
		w = '0;
		w.last = 1'b1;
		case (it.op)
			REQ_CREATE: begin
				slot = find_binding(ID_EMPTY, ID_EMPTY);
				if (slot < 0) begin
					w.status = STAT_FULL;
				end else begin
					bind_sender[slot]   = it.sender;
					bind_receiver[slot] = it.receiver;
					bind_perms[slot]    = it.perm;
				end
			end
			REQ_GET: begin
				slot = find_binding(it.sender, it.receiver);
				if (slot < 0) w.status = STAT_NOT_FOUND;
				else w.perm = bind_perms[slot];
			end
			REQ_UPDATE: begin
				slot = find_binding(it.sender, it.receiver);
				if (slot < 0) w.status = STAT_NOT_FOUND;
				else bind_perms[slot] = it.perm;
			end
			REQ_DESTROY: begin
				slot = find_binding(it.sender, it.receiver);
				if (slot < 0) begin
					w.status = STAT_NOT_FOUND;
				end else begin
					w.notify = 1'b1;
					w.target = notify_peer(slot, it.requester);
					w.about  = it.requester;
					clear_binding(slot);
				end
			end
			REQ_CLEANUP: begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (bind_sender[i] == it.requester) begin
						w.notify = 1'b1;
						w.target = notify_peer(i, it.requester);
						w.about  = it.requester;
						w.last   = 1'b0;
						due_replies.push_back(w);
						clear_binding(i);
					end else if (bind_receiver[i] == it.requester) begin
						clear_binding(i);
					end
				end
				w = '0;
				w.last = 1'b1;
			end
			default: w.status = STAT_NOT_FOUND;
		endcase
		due_replies.push_back(w);
	endfunction

	function automatic logic [7:0] pick_id();
		logic [7:0] pool [6];
		pool = '{8'h00, ID_EMPTY, 8'h5a, 8'ha5, 8'h01, 8'h80};
		if ($urandom_range(9) < 7) return pool[$urandom_range(5)];
		return 8'($urandom);
	endfunction

	function automatic req_item_t random_request(int create_w);
		req_item_t it;
		int        roll;
		int        slot;
		it.perm      = $urandom;
		it.sender    = pick_id();
		it.receiver  = pick_id();
		it.requester = pick_id();
		roll = $urandom_range(99);
		if (roll < create_w) begin
			it.op = REQ_CREATE;
		end else if (roll < 97) begin
			case ($urandom_range(9))
				0, 1, 2: it.op = REQ_GET;
				3, 4, 5: it.op = REQ_UPDATE;
				6, 7, 8: it.op = REQ_DESTROY;
				default: it.op = REQ_CLEANUP;
			endcase
			// aim most lookups at an entry of the table copy, live or free
			if ($urandom_range(9) < 6) begin
				slot = $urandom_range(TABLE_ENTRIES - 1);
				it.sender   = bind_sender[slot];
				it.receiver = bind_receiver[slot];
			end
			if ($urandom_range(1)) it.requester = $urandom_range(1) ? it.receiver : it.sender;
		end else begin
			it.op = 3'($urandom_range(REQ_BAD_HI, REQ_BAD_LO));
		end
		return it;
	endfunction

	function automatic void add_row(logic [2:0] op, logic [7:0] s, logic [7:0] r,
			logic [PERM_W-1:0] perm, logic [7:0] req, logic fixed,
			logic [1:0] st, logic [PERM_W-1:0] perm_rd);
		dir_row_t row;
		row.it        = '{op: op, sender: s, receiver: r, perm: perm, requester: req};
		row.fixed     = fixed;
		row.want      = '0;
		row.want.status = st;
		row.want.perm   = perm_rd;
		row.want.last   = 1'b1;
		directed_rows.push_back(row);
	endfunction

	task automatic send_request(req_item_t it, logic fixed, rsp_word_t want);
		while (!quiet && $urandom_range(99) < 8) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_type       <= it.op;
		sender_id      <= it.sender;
		receiver_id    <= it.receiver;
		perm_in        <= it.perm;
		requester_id   <= it.requester;
		cur_fixed      <= fixed;
		cur_fixed_word <= want;
		req_valid      <= 1'b1;
		do @(posedge clk); while (!(req_valid && !req_stall));
	endtask

	task automatic drain_replies();
		req_valid <= 1'b0;
		do @(posedge clk); while (due_replies.size() != 0);
	endtask

	task automatic random_phase(int count, int create_w);
		for (int n = 0; n < count; n++) send_request(random_request(create_w), 1'b0, '0);
	endtask

	// receiver: random stalls, plus a long hold-off whenever one is asked for
	always @(posedge clk) begin
		if (bursts_done != bursts_asked) begin
			bursts_done <= bursts_done + 1;
			hold_left   <= HOLD_CYCLES;
			rsp_stall   <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !quiet && ($urandom_range(99) < 8);
		end
	end

	always @(posedge clk) begin : monitor
		rsp_word_t want;
		req_item_t seen;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (due_replies.size() == 0) begin
					$error("result word with nothing due: status %0d last %0d", status, last);
					errors++;
				end else begin
					want = due_replies.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (perm_out !== want.perm) begin
						$error("perm_out: expected %h, got %h", want.perm, perm_out);
						errors++;
					end
					if (notify_valid !== want.notify) begin
						$error("notify_valid: expected %0d, got %0d", want.notify, notify_valid);
						errors++;
					end
					if (notify_target !== want.target) begin
						$error("notify_target: expected %h, got %h", want.target, notify_target);
						errors++;
					end
					if (notify_about !== want.about) begin
						$error("notify_about: expected %h, got %h", want.about, notify_about);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						errors++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				seen = '{op: req_type, sender: sender_id, receiver: receiver_id,
					perm: perm_in, requester: requester_id};
				apply_request(seen);
				if (cur_fixed) begin
					due_replies.delete(due_replies.size() - 1);
					due_replies.push_back(cur_fixed_word);
				end
			end
		end
	end

	initial begin
		#6_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		for (int i = 0; i < TABLE_ENTRIES; i++) clear_binding(i);

		add_row(REQ_GET,     8'h00, 8'h00, '0, 8'h00, 1'b1, STAT_NOT_FOUND, '0);
		// both ids empty match the first free entry
		add_row(REQ_UPDATE,  ID_EMPTY, ID_EMPTY, 32'h1357_9bdf, 8'h00, 1'b0, STAT_OK, '0);
		add_row(REQ_GET,     ID_EMPTY, ID_EMPTY, '0, 8'h00, 1'b0, STAT_OK, '0);
		add_row(REQ_CREATE,  8'h00, ID_EMPTY, 32'hffff_ffff, 8'h00, 1'b1, STAT_OK, '0);
		add_row(REQ_CREATE,  ID_EMPTY, 8'h00, '0, ID_EMPTY, 1'b1, STAT_OK, '0);
		add_row(REQ_CREATE,  8'h12, 8'h34, 32'ha5a5_a5a5, 8'h00, 1'b0, STAT_OK, '0);
		add_row(REQ_GET,     8'h00, ID_EMPTY, '0, 8'h00, 1'b1, STAT_OK, 32'hffff_ffff);
		add_row(REQ_GET,     ID_EMPTY, 8'h00, 32'hffff_ffff, 8'h00, 1'b1, STAT_OK, '0);
		add_row(REQ_UPDATE,  8'h12, 8'h34, 32'h5a5a_5a5a, 8'h00, 1'b0, STAT_OK, '0);
		add_row(REQ_GET,     8'h12, 8'h34, '0, 8'h00, 1'b0, STAT_OK, '0);
		add_row(REQ_DESTROY, 8'h12, 8'h34, '0, 8'h34, 1'b0, STAT_OK, '0);
		add_row(REQ_DESTROY, 8'h12, 8'h34, '0, 8'h34, 1'b1, STAT_NOT_FOUND, '0);
		add_row(REQ_BAD_LO,     8'h12, 8'h34, '0, 8'h00, 1'b1, STAT_NOT_FOUND, '0);
		add_row(REQ_BAD_LO + 3'd1, 8'h00, 8'h00, '0, 8'h00, 1'b1, STAT_NOT_FOUND, '0);
		add_row(REQ_BAD_HI,     ID_EMPTY, ID_EMPTY, '1, ID_EMPTY, 1'b1, STAT_NOT_FOUND, '0);
		add_row(REQ_CREATE,  8'h07, 8'h08, 32'h0000_0001, 8'h00, 1'b0, STAT_OK, '0);
		add_row(REQ_CREATE,  8'h08, 8'h07, 32'h8000_0000, 8'h00, 1'b0, STAT_OK, '0);
		add_row(REQ_CREATE,  8'h07, 8'h09, 32'h0000_ffff, 8'h00, 1'b0, STAT_OK, '0);
		add_row(REQ_CLEANUP, 8'h00, 8'h00, '0, 8'h07, 1'b0, STAT_OK, '0);
		// cleanup of the empty id hits every free entry
		add_row(REQ_CLEANUP, 8'h00, 8'h00, '0, ID_EMPTY, 1'b0, STAT_OK, '0);
		add_row(REQ_CLEANUP, 8'h00, 8'h00, '0, ID_EMPTY, 1'b0, STAT_OK, '0);
		add_row(REQ_DESTROY, ID_EMPTY, ID_EMPTY, '0, ID_EMPTY, 1'b0, STAT_OK, '0);
		add_row(REQ_CLEANUP, 8'h00, 8'h00, '0, 8'h00, 1'b1, STAT_OK, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].want);
		drain_replies();

		random_phase(100, 45);
		bursts_asked++;
		random_phase(60, 35);
		drain_replies();
		quiet = 1'b1;
		random_phase(80, 40);
		quiet = 1'b0;
		// fill the table past full
		random_phase(18, 100);
		drain_replies();
		random_phase(90, 30);

		drain_replies();
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
